// ===== design/ray_box_slab_intersect_top_defines.svh =====
// Assertion macros shared by the ray/box intersection checkers.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RBS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rbs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the ray/box slab test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int unsigned Q_SHIFT   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DIST_W    = 31;
    localparam int unsigned NUM_AXES  = 3;

    typedef logic signed [31:0] t_q16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X    = 3'd0,
        CFG_MIN_Y    = 3'd1,
        CFG_MIN_Z    = 3'd2,
        CFG_MAX_X    = 3'd3,
        CFG_MAX_Y    = 3'd4,
        CFG_MAX_Z    = 3'd5,
        CFG_MIN_DIST = 3'd6,
        CFG_FACE_TOL = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FACE_NEG_X = 3'd0,
        FACE_POS_X = 3'd1,
        FACE_NEG_Y = 3'd2,
        FACE_POS_Y = 3'd3,
        FACE_NEG_Z = 3'd4,
        FACE_POS_Z = 3'd5,
        FACE_NONE  = 3'd6
    } t_face;

    typedef struct packed {
        t_q16 [NUM_AXES-1:0] org;
        t_q16 [NUM_AXES-1:0] dir;
    } t_ray;

    localparam t_q16              BOX_MIN_RST  = 32'sd0;
    localparam t_q16              BOX_MAX_RST  = 32'sd65536;
    localparam logic [DIST_W-1:0] MIN_DIST_RST = 31'd32768;
    localparam logic [DIST_W-1:0] FACE_TOL_RST = 31'd655;

    localparam logic signed [64:0] S65_MAX = 65'sd2147483647;
    localparam logic signed [64:0] S65_MIN = -65'sd2147483648;

    // Floor shift of a Q32.32 product back to Q16.16, clamped to 32 bits.
    function automatic t_q16 sat_shift(input logic signed [64:0] p);
        logic signed [64:0] s;
        s = p >>> Q_SHIFT;
        if (s > S65_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (s < S65_MIN) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // Clamp an exact 33-bit sum to 32 bits.
    function automatic t_q16 sat_sum(input logic signed [32:0] s);
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

endpackage

// ===== design/rbs_slab.sv =====
// One axis of the slab test: plane offsets, products, near/far ordering.
// Three register stages; depends on rbs_pkg.
`timescale 1ns / 1ps

module rbs_slab (
    input  logic         i_clk,
    input  logic         i_en,
    input  rbs_pkg::t_q16 i_org,
    input  rbs_pkg::t_q16 i_inv,
    input  rbs_pkg::t_q16 i_lo,
    input  rbs_pkg::t_q16 i_hi,
    output rbs_pkg::t_q16 o_tn,
    output rbs_pkg::t_q16 o_tf
);
    import rbs_pkg::*;

    logic signed [32:0] r_d0, r_d1;
    t_q16               r_inv;
    logic signed [64:0] r_p0, r_p1;
    logic signed [64:0] n_p0, n_p1;
    t_q16               n_t0, n_t1;
    t_q16               r_tn, r_tf;

    always_comb begin
        n_p0 = r_d0 * r_inv;
        n_p1 = r_d1 * r_inv;
        n_t0 = sat_shift(r_p0);
        n_t1 = sat_shift(r_p1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d0  <= {i_lo[31], i_lo} - {i_org[31], i_org};
            r_d1  <= {i_hi[31], i_hi} - {i_org[31], i_org};
            r_inv <= i_inv;
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_tn  <= (n_t0 < n_t1) ? n_t0 : n_t1;
            r_tf  <= (n_t0 < n_t1) ? n_t1 : n_t0;
        end
    end

    assign o_tn = r_tn;
    assign o_tf = r_tf;

endmodule

// ===== design/rbs_hitpt.sv =====
// One axis of the hit point: entry distance times direction, plus origin.
// Two register stages; depends on rbs_pkg.
`timescale 1ns / 1ps

module rbs_hitpt (
    input  logic          i_clk,
    input  logic          i_en,
    input  rbs_pkg::t_q16 i_enter,
    input  rbs_pkg::t_q16 i_dir,
    input  rbs_pkg::t_q16 i_org,
    output rbs_pkg::t_q16 o_pt
);
    import rbs_pkg::*;

    logic signed [63:0] r_p;
    logic signed [63:0] n_p;
    t_q16               r_org;
    t_q16               n_step;
    t_q16               r_pt;

    always_comb begin
        n_p    = i_enter * i_dir;
        n_step = sat_shift({r_p[63], r_p});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_org <= i_org;
            r_pt  <= sat_sum({r_org[31], r_org} + {n_step[31], n_step});
        end
    end

    assign o_pt = r_pt;

endmodule

// ===== design/ray_box_slab_intersect_top.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbs_pkg, rbs_slab and rbs_hitpt.
`timescale 1ns / 1ps

// Streams one ray per cycle against a box held in configuration registers and returns
// one result beat per ray, in order. Each ray passes through three slab stages per axis
// (plane offsets, 33x32 products, clamp and near/far sort), one stage that reduces the
// three axes to entry/exit distances and decides the miss, two hit point stages
// (32x32 product, clamp and add origin) and the face/output register. The multipliers
// set the stage depth. Throughput is one beat per cycle while the output is not stalled;
// a stall against a valid output beat freezes the whole pipeline, and o_stall follows it
// in the same cycle. The configuration port is always ready; write it only while no ray
// is in flight, since the stages read the box registers live. Misses report zero
// distance and point and face code none.
module ray_box_slab_intersect_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    // ray input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  rbs_pkg::t_q16                      i_origin_x,
    input  rbs_pkg::t_q16                      i_origin_y,
    input  rbs_pkg::t_q16                      i_origin_z,
    input  rbs_pkg::t_q16                      i_dir_x,
    input  rbs_pkg::t_q16                      i_dir_y,
    input  rbs_pkg::t_q16                      i_dir_z,
    input  rbs_pkg::t_q16                      i_inv_dir_x,
    input  rbs_pkg::t_q16                      i_inv_dir_y,
    input  rbs_pkg::t_q16                      i_inv_dir_z,
    // result output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit,
    output rbs_pkg::t_q16                      o_distance,
    output rbs_pkg::t_q16                      o_point_x,
    output rbs_pkg::t_q16                      o_point_y,
    output rbs_pkg::t_q16                      o_point_z,
    output logic [2:0]                         o_face
);
    import rbs_pkg::*;

    localparam int unsigned RAY_DLY = 4;   // origin and direction wait for the entry distance
    localparam int unsigned DEPTH   = 7;

    // configuration registers
    t_q16 [NUM_AXES-1:0]  r_box_lo;
    t_q16 [NUM_AXES-1:0]  r_box_hi;
    logic [DIST_W-1:0]    r_min_dist;
    logic [DIST_W-1:0]    r_face_tol;

    // pipeline control
    logic                 w_en;
    logic [DEPTH-1:0]     r_vld;

    // payload
    t_q16 [NUM_AXES-1:0]  w_org_in;
    t_q16 [NUM_AXES-1:0]  w_dir_in;
    t_q16 [NUM_AXES-1:0]  w_inv_in;
    t_ray                 r_ray_dly [RAY_DLY];
    t_q16 [NUM_AXES-1:0]  w_tn;
    t_q16 [NUM_AXES-1:0]  w_tf;
    t_q16                 n_enter, n_leave;
    logic                 n_hit;
    t_q16                 r_enter4, r_enter5, r_enter6;
    logic                 r_hit4, r_hit5, r_hit6;
    t_q16 [NUM_AXES-1:0]  w_pt;
    t_face                n_face;

    logic                 r_hit;
    t_q16                 r_dist;
    t_q16 [NUM_AXES-1:0]  r_pt;
    t_face                r_face;

    // Strictly inside the tolerance band around a plane.
    function automatic logic near_plane(input t_q16 p, input t_q16 plane,
                                        input logic [DIST_W-1:0] tol);
        logic signed [32:0] d;
        logic [32:0]        mag;
        d   = {p[31], p} - {plane[31], plane};
        mag = d[32] ? 33'(-d) : 33'(d);
        return mag < {2'b00, tol};
    endfunction

    // ---------------------------------------------------------------------
    // Configuration: always ready, out-of-list indexes have no target.
    // ---------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_lo   <= {NUM_AXES{BOX_MIN_RST}};
            r_box_hi   <= {NUM_AXES{BOX_MAX_RST}};
            r_min_dist <= MIN_DIST_RST;
            r_face_tol <= FACE_TOL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X:    r_box_lo[0] <= i_cfg_data;
                CFG_MIN_Y:    r_box_lo[1] <= i_cfg_data;
                CFG_MIN_Z:    r_box_lo[2] <= i_cfg_data;
                CFG_MAX_X:    r_box_hi[0] <= i_cfg_data;
                CFG_MAX_Y:    r_box_hi[1] <= i_cfg_data;
                CFG_MAX_Z:    r_box_hi[2] <= i_cfg_data;
                CFG_MIN_DIST: r_min_dist  <= i_cfg_data[DIST_W-1:0];
                CFG_FACE_TOL: r_face_tol  <= i_cfg_data[DIST_W-1:0];
                default:      r_min_dist  <= r_min_dist;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline control: advance everything unless the output beat is held.
    // ---------------------------------------------------------------------
    assign w_en    = !(r_vld[DEPTH-1] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    assign w_org_in = {i_origin_z, i_origin_y, i_origin_x};
    assign w_dir_in = {i_dir_z, i_dir_y, i_dir_x};
    assign w_inv_in = {i_inv_dir_z, i_inv_dir_y, i_inv_dir_x};

    // Hold origin and direction alongside the slab stages.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ray_dly[0] <= '{org: w_org_in, dir: w_dir_in};
            for (int k = 1; k < RAY_DLY; k++) begin
                r_ray_dly[k] <= r_ray_dly[k-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stages 1-3: per-axis slab times.
    // ---------------------------------------------------------------------
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_slab
        rbs_slab u_slab (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_org (w_org_in[a]),
            .i_inv (w_inv_in[a]),
            .i_lo  (r_box_lo[a]),
            .i_hi  (r_box_hi[a]),
            .o_tn  (w_tn[a]),
            .o_tf  (w_tf[a])
        );
    end

    // ---------------------------------------------------------------------
    // Stage 4: entry is the latest near time, exit the earliest far time.
    // ---------------------------------------------------------------------
    always_comb begin
        n_enter = w_tn[0];
        n_leave = w_tf[0];
        for (int a = 1; a < NUM_AXES; a++) begin
            if (w_tn[a] > n_enter) begin
                n_enter = w_tn[a];
            end
            if (w_tf[a] < n_leave) begin
                n_leave = w_tf[a];
            end
        end
        n_hit = !((n_enter >= n_leave) || n_leave[31] ||
                  (n_enter < t_q16'({1'b0, r_min_dist})));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_enter4 <= n_enter;
            r_hit4   <= n_hit;
            r_enter5 <= r_enter4;
            r_hit5   <= r_hit4;
            r_enter6 <= r_enter5;
            r_hit6   <= r_hit5;
        end
    end

    // ---------------------------------------------------------------------
    // Stages 5-6: hit point per axis.
    // ---------------------------------------------------------------------
    for (genvar a = 0; a < NUM_AXES; a++) begin : g_hitpt
        rbs_hitpt u_hitpt (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_enter (r_enter4),
            .i_dir   (r_ray_dly[RAY_DLY-1].dir[a]),
            .i_org   (r_ray_dly[RAY_DLY-1].org[a]),
            .o_pt    (w_pt[a])
        );
    end

    // ---------------------------------------------------------------------
    // Stage 7: face pick in -x,+x,-y,+y,-z,+z order, output register.
    // ---------------------------------------------------------------------
    always_comb begin
        n_face = FACE_NONE;
        if (near_plane(w_pt[0], r_box_lo[0], r_face_tol)) begin
            n_face = FACE_NEG_X;
        end else if (near_plane(w_pt[0], r_box_hi[0], r_face_tol)) begin
            n_face = FACE_POS_X;
        end else if (near_plane(w_pt[1], r_box_lo[1], r_face_tol)) begin
            n_face = FACE_NEG_Y;
        end else if (near_plane(w_pt[1], r_box_hi[1], r_face_tol)) begin
            n_face = FACE_POS_Y;
        end else if (near_plane(w_pt[2], r_box_lo[2], r_face_tol)) begin
            n_face = FACE_NEG_Z;
        end else if (near_plane(w_pt[2], r_box_hi[2], r_face_tol)) begin
            n_face = FACE_POS_Z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hit  <= r_hit6;
            r_dist <= r_hit6 ? r_enter6 : '0;
            r_pt   <= r_hit6 ? w_pt : '0;
            r_face <= r_hit6 ? n_face : FACE_NONE;
        end
    end

    assign o_valid    = r_vld[DEPTH-1];
    assign o_hit      = r_hit;
    assign o_distance = r_dist;
    assign o_point_x  = r_pt[0];
    assign o_point_y  = r_pt[1];
    assign o_point_z  = r_pt[2];
    assign o_face     = r_face;

endmodule

// ===== design/rbs_checker.sv =====
// Port-level checks for the ray/box slab block, bound to its top level.
// Depends on rbs_pkg and ray_box_slab_intersect_top_defines.svh.
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_top_defines.svh"

module rbs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic                          o_hit,
    input rbs_pkg::t_q16                 o_distance,
    input rbs_pkg::t_q16                 o_point_x,
    input rbs_pkg::t_q16                 o_point_y,
    input rbs_pkg::t_q16                 o_point_z,
    input logic [2:0]                    o_face
);
    import rbs_pkg::*;

    // A held result beat stays put.
    `RBS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_hit) && $stable(o_distance) && $stable(o_face) &&
        $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_z),
        "result beat changed while stalled")

    // Back-pressure only comes from a held output beat.
    `RBS_ASSERT_NOW(a_stall_src, i_clk, i_rst_n, o_stall,
        o_valid && i_stall, "input stalled without a held output")

    // A miss carries zeros and no face.
    `RBS_ASSERT_NOW(a_miss_shape, i_clk, i_rst_n, o_valid && !o_hit,
        (o_distance == '0) && (o_point_x == '0) && (o_point_y == '0) &&
        (o_point_z == '0) && (o_face == FACE_NONE),
        "miss beat with nonzero payload")

    // A hit lies at or beyond the minimum distance, which is never negative.
    `RBS_ASSERT_NOW(a_hit_dist, i_clk, i_rst_n, o_valid && o_hit,
        !o_distance[31], "hit with negative distance")

endmodule

bind ray_box_slab_intersect_top rbs_checker u_rbs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_hit      (o_hit),
    .o_distance (o_distance),
    .o_point_x  (o_point_x),
    .o_point_y  (o_point_y),
    .o_point_z  (o_point_z),
    .o_face     (o_face)
);

// ===== test/ray_box_slab_intersect_top_tb.sv =====
// Self-checking bench for ray_box_slab_intersect_top: rays against a configurable box.
// Depends on rbs_pkg and the block's RTL; predicts each result beat and compares in order.
`timescale 1ns / 1ps

module ray_box_slab_intersect_top_tb;
    import rbs_pkg::*;

    localparam int     CLK_HALF_NS    = 10;
    localparam int     PIPE_DEPTH     = 7;
    localparam int     HOLDOFF_CYCLES = 80;
    localparam longint TIMEOUT_NS     = 64'd4_000_000;
    localparam longint ONE_Q          = 65536;
    localparam longint HALF_Q         = 32768;
    localparam longint Q16_MAX        = 64'sd2147483647;
    localparam longint Q16_MIN        = -64'sd2147483648;

    localparam t_cfg_idx MIN_REG[3]   = '{CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z};
    localparam t_cfg_idx MAX_REG[3]   = '{CFG_MAX_X, CFG_MAX_Y, CFG_MAX_Z};
    localparam t_face    LOW_FACE[3]  = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
    localparam t_face    HIGH_FACE[3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

    // Traffic shaping per phase: who inserts gaps, and how often.
    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SEND_GAPS,
        TRAFFIC_RECV_STALLS,
        TRAFFIC_BOTH
    } t_traffic;

    // One ray beat: origin, direction and reciprocal direction per axis.
    typedef struct packed {
        t_q16 [2:0] org;
        t_q16 [2:0] dir;
        t_q16 [2:0] inv;
    } t_ray_beat;

    // One intersection outcome as the block reports it.
    typedef struct packed {
        logic       hit;
        t_q16       distance;
        t_q16       point_x;
        t_q16       point_y;
        t_q16       point_z;
        logic [2:0] face;
    } t_box_hit;

    // DUT ports; every input starts at a known value.
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [2:0]       i_cfg_index = '0;
    logic [31:0]      i_cfg_data  = '0;
    logic             i_valid     = 1'b0;
    logic             o_stall;
    t_q16             i_origin_x  = '0;
    t_q16             i_origin_y  = '0;
    t_q16             i_origin_z  = '0;
    t_q16             i_dir_x     = '0;
    t_q16             i_dir_y     = '0;
    t_q16             i_dir_z     = '0;
    t_q16             i_inv_dir_x = '0;
    t_q16             i_inv_dir_y = '0;
    t_q16             i_inv_dir_z = '0;
    logic             o_valid;
    logic             i_stall     = 1'b0;
    logic             o_hit;
    t_q16             o_distance;
    t_q16             o_point_x;
    t_q16             o_point_y;
    t_q16             o_point_z;
    logic [2:0]       o_face;

    // Shadow copy of the box registers, updated at each config handshake.
    longint           box_lo[3];
    longint           box_hi[3];
    longint           min_dist;
    longint           face_tol;

    t_ray_beat        rays_to_send[$];
    t_box_hit         predicted_hits[$];
    t_ray_beat        beat_on_bus;
    t_traffic         traffic_mode  = TRAFFIC_STEADY;
    logic             holdoff_start = 1'b0;
    int               holdoff_left  = 0;
    int               mismatch_count = 0;

    ray_box_slab_intersect_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_origin_z  (i_origin_z),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .i_inv_dir_x (i_inv_dir_x),
        .i_inv_dir_y (i_inv_dir_y),
        .i_inv_dir_z (i_inv_dir_z),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_distance  (o_distance),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_face      (o_face)
    );

    initial begin
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers and the intersection predictor
    // ------------------------------------------------------------------

    function automatic longint clamp_q16(input longint x);
        if (x > Q16_MAX) return Q16_MAX;
        if (x < Q16_MIN) return Q16_MIN;
        return x;
    endfunction

    // Exact product of two Q16.16 values, floored back to Q16.16, clamped to 32 bits.
    // Operands can reach 33 bits, so the product needs more than 64.
    function automatic longint fix_mul(input longint a, input longint b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        logic signed [65:0] prod;
        wa   = a;
        wb   = b;
        prod = (wa * wb) >>> Q_SHIFT;
        if (prod > 66'sd2147483647) return Q16_MAX;
        if (prod < -66'sd2147483648) return Q16_MIN;
        return longint'($signed(prod[31:0]));
    endfunction

    function automatic longint abs_gap(input longint a, input longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Slab test of one ray against the shadow box.
    function automatic t_box_hit trace_ray(input t_ray_beat r);
        longint   org[3];
        longint   dir[3];
        longint   inv[3];
        longint   pt[3];
        longint   t0;
        longint   t1;
        longint   t_near;
        longint   t_far;
        longint   enter_t;
        longint   leave_t;
        t_box_hit res;
        enter_t = 0;
        leave_t = 0;
        for (int a = 0; a < 3; a++) begin
            org[a] = longint'($signed(r.org[a]));
            dir[a] = longint'($signed(r.dir[a]));
            inv[a] = longint'($signed(r.inv[a]));
        end
        for (int a = 0; a < 3; a++) begin
            t0     = fix_mul(box_lo[a] - org[a], inv[a]);
            t1     = fix_mul(box_hi[a] - org[a], inv[a]);
            t_near = (t0 < t1) ? t0 : t1;
            t_far  = (t0 < t1) ? t1 : t0;
            if (a == 0 || t_near > enter_t) enter_t = t_near;
            if (a == 0 || t_far < leave_t) leave_t = t_far;
        end
        res      = '0;
        res.face = FACE_NONE;
        // Miss: empty interval, box behind the ray, or entry too close.
        if (enter_t >= leave_t || leave_t < 0 || enter_t < min_dist) return res;
        for (int a = 0; a < 3; a++) begin
            pt[a] = clamp_q16(org[a] + fix_mul(enter_t, dir[a]));
        end
        res.hit      = 1'b1;
        res.distance = t_q16'(enter_t);
        res.point_x  = t_q16'(pt[0]);
        res.point_y  = t_q16'(pt[1]);
        res.point_z  = t_q16'(pt[2]);
        // First plane within tolerance wins, low side before high side per axis.
        for (int a = 0; a < 3 && res.face == FACE_NONE; a++) begin
            if (abs_gap(pt[a], box_lo[a]) < face_tol) begin
                res.face = LOW_FACE[a];
            end else if (abs_gap(pt[a], box_hi[a]) < face_tol) begin
                res.face = HIGH_FACE[a];
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    function automatic t_ray_beat ray_of(input longint ox, input longint oy, input longint oz,
                                         input longint dx, input longint dy, input longint dz,
                                         input longint ix, input longint iy, input longint iz);
        t_ray_beat r;
        r.org[0] = t_q16'(ox);
        r.org[1] = t_q16'(oy);
        r.org[2] = t_q16'(oz);
        r.dir[0] = t_q16'(dx);
        r.dir[1] = t_q16'(dy);
        r.dir[2] = t_q16'(dz);
        r.inv[0] = t_q16'(ix);
        r.inv[1] = t_q16'(iy);
        r.inv[2] = t_q16'(iz);
        return r;
    endfunction

    // Q16.16 reciprocal as the traversal engine would supply it; zero saturates.
    function automatic longint recip_q16(input longint d);
        if (d == 0) return ($urandom_range(1) != 0) ? Q16_MAX : Q16_MIN;
        return clamp_q16((longint'(1) << 32) / d);
    endfunction

    function automatic longint corner_value();
        case ($urandom_range(4))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return Q16_MAX;
            default: return Q16_MIN;
        endcase
    endfunction

    // Mostly rays aimed at a random point of the current box from a random origin
    // around it; the rest are raw noise, partly built from corner values.
    function automatic t_ray_beat make_ray();
        t_ray_beat r;
        longint    lo;
        longint    span;
        longint    margin;
        longint    target;
        longint    origin;
        longint    d;
        if ($urandom_range(99) < 25) begin
            for (int a = 0; a < 3; a++) begin
                if ($urandom_range(3) == 0) begin
                    r.org[a] = t_q16'(corner_value());
                    r.dir[a] = t_q16'(corner_value());
                    r.inv[a] = t_q16'(corner_value());
                end else begin
                    r.org[a] = t_q16'($urandom);
                    r.dir[a] = t_q16'($urandom);
                    r.inv[a] = t_q16'($urandom);
                end
            end
            return r;
        end
        for (int a = 0; a < 3; a++) begin
            lo     = (box_lo[a] < box_hi[a]) ? box_lo[a] : box_hi[a];
            span   = abs_gap(box_lo[a], box_hi[a]);
            margin = span + 4 * ONE_Q;
            target = lo + (longint'($urandom) % (span + 1));
            origin = clamp_q16(lo - margin + (longint'($urandom) % (span + 2 * margin + 1)));
            d      = (target - origin) >>> $urandom_range(3);
            while (d > Q16_MAX || d < Q16_MIN) d = d >>> 1;
            if ($urandom_range(7) == 0) d = 0;
            r.org[a] = t_q16'(origin);
            r.dir[a] = t_q16'(d);
            r.inv[a] = t_q16'(recip_q16(d));
        end
        return r;
    endfunction

    // Probability of a gap on one side under the current traffic mode.
    function automatic bit roll_gap(input bit receiver_side);
        int pct;
        pct = 0;
        case (traffic_mode)
            TRAFFIC_SEND_GAPS:   pct = receiver_side ? 0 : 66;
            TRAFFIC_RECV_STALLS: pct = receiver_side ? 66 : 0;
            TRAFFIC_BOTH:        pct = 24;
            default:             pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer rays from the queue, hold a stalled beat unchanged
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // Predict on acceptance, with the box as it stands now.
            if (i_valid && !o_stall) begin
                predicted_hits.push_back(trace_ray(beat_on_bus));
            end
            // Advance only when the bus is free or the current beat just went.
            if (!i_valid || !o_stall) begin
                if (rays_to_send.size() != 0 && !roll_gap(1'b0)) begin
                    beat_on_bus = rays_to_send.pop_front();
                    i_origin_x  <= beat_on_bus.org[0];
                    i_origin_y  <= beat_on_bus.org[1];
                    i_origin_z  <= beat_on_bus.org[2];
                    i_dir_x     <= beat_on_bus.dir[0];
                    i_dir_y     <= beat_on_bus.dir[1];
                    i_dir_z     <= beat_on_bus.dir[2];
                    i_inv_dir_x <= beat_on_bus.inv[0];
                    i_inv_dir_y <= beat_on_bus.inv[1];
                    i_inv_dir_z <= beat_on_bus.inv[2];
                    i_valid     <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: retire result beats against the oldest prediction
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] expv,
                                 input logic [31:0] gotv);
        if (gotv !== expv) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, expv, gotv);
            mismatch_count++;
        end
    endtask

    task automatic retire_result();
        t_box_hit exp_hit;
        if (predicted_hits.size() == 0) begin
            $error("result beat with no ray outstanding");
            mismatch_count++;
        end else begin
            exp_hit = predicted_hits.pop_front();
            compare_field("hit",      32'(exp_hit.hit),  32'(o_hit));
            compare_field("distance", exp_hit.distance,  o_distance);
            compare_field("point_x",  exp_hit.point_x,   o_point_x);
            compare_field("point_y",  exp_hit.point_y,   o_point_y);
            compare_field("point_z",  exp_hit.point_z,   o_point_z);
            compare_field("face",     32'(exp_hit.face), 32'(o_face));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) retire_result();
            // Stall during a hold-off stretch, otherwise at the phase's random rate.
            i_stall <= (holdoff_left > 1) || roll_gap(1'b1);
        end
    end

    // Hold-off stretch counter: load on request, count down each cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
        end else if (holdoff_start) begin
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing tasks
    // ------------------------------------------------------------------

    // Write one register and mirror it into the shadow box at the handshake.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_X, CFG_MIN_Y, CFG_MIN_Z: box_lo[int'(idx)] = longint'($signed(data));
            CFG_MAX_X, CFG_MAX_Y, CFG_MAX_Z:
                box_hi[int'(idx) - int'(CFG_MAX_X)] = longint'($signed(data));
            CFG_MIN_DIST: min_dist = longint'(data[30:0]);
            CFG_FACE_TOL: face_tol = longint'(data[30:0]);
            default: ;
        endcase
    endtask

    // Random box of modest size; the top bit of the unsigned registers is noise.
    task automatic random_box(input bit swap_corners);
        longint lo;
        longint hi;
        for (int a = 0; a < 3; a++) begin
            lo = longint'($urandom_range(16 * ONE_Q)) - 8 * ONE_Q;
            hi = lo + longint'($urandom_range(8 * ONE_Q, ONE_Q / 4));
            write_reg(MIN_REG[a], swap_corners ? 32'(hi) : 32'(lo));
            write_reg(MAX_REG[a], swap_corners ? 32'(lo) : 32'(hi));
        end
        write_reg(CFG_MIN_DIST, {1'($urandom), 31'($urandom_range(ONE_Q))});
        write_reg(CFG_FACE_TOL, {1'($urandom), 31'($urandom_range(4000, 64))});
    endtask

    task automatic set_traffic(input t_traffic mode);
        @(posedge i_clk);
        traffic_mode <= mode;
    endtask

    // Queue rays away from the sampling edge so the driver sees them cleanly.
    task automatic queue_rays(input int count);
        @(negedge i_clk);
        repeat (count) rays_to_send.push_back(make_ray());
    endtask

    // Wait until every queued ray is accepted and every result retired, then keep
    // waiting so nothing stray is still in flight.
    task automatic drain_pipe();
        do @(negedge i_clk);
        while (rays_to_send.size() != 0 || i_valid || predicted_hits.size() != 0);
        repeat (PIPE_DEPTH + 3) @(negedge i_clk);
    endtask

    // Hand-picked rays against the reset box [0,1]^3, entry limit 0.5.
    task automatic queue_directed();
        @(negedge i_clk);
        // Axis-parallel hits on each of the six faces; zero components carry
        // a saturated reciprocal.
        rays_to_send.push_back(ray_of(-ONE_Q, HALF_Q, HALF_Q, ONE_Q, 0, 0,
                                      ONE_Q, Q16_MAX, Q16_MAX));
        rays_to_send.push_back(ray_of(2 * ONE_Q, HALF_Q, HALF_Q, -ONE_Q, 0, 0,
                                      -ONE_Q, Q16_MAX, Q16_MAX));
        rays_to_send.push_back(ray_of(HALF_Q, -ONE_Q, HALF_Q, 0, ONE_Q, 0,
                                      Q16_MAX, ONE_Q, Q16_MAX));
        rays_to_send.push_back(ray_of(HALF_Q, 2 * ONE_Q, HALF_Q, 0, -ONE_Q, 0,
                                      Q16_MAX, -ONE_Q, Q16_MAX));
        rays_to_send.push_back(ray_of(HALF_Q, HALF_Q, -ONE_Q, 0, 0, ONE_Q,
                                      Q16_MAX, Q16_MAX, ONE_Q));
        rays_to_send.push_back(ray_of(HALF_Q, HALF_Q, 2 * ONE_Q, 0, 0, -ONE_Q,
                                      Q16_MAX, Q16_MAX, -ONE_Q));
        // Negative saturated reciprocal on the zero components.
        rays_to_send.push_back(ray_of(-ONE_Q, HALF_Q, HALF_Q, ONE_Q, 0, 0,
                                      ONE_Q, Q16_MIN, Q16_MIN));
        // Box behind the ray.
        rays_to_send.push_back(ray_of(-ONE_Q, HALF_Q, HALF_Q, -ONE_Q, 0, 0,
                                      -ONE_Q, Q16_MAX, Q16_MAX));
        // Passes beside the box: empty interval.
        rays_to_send.push_back(ray_of(-ONE_Q, 2 * ONE_Q, HALF_Q, ONE_Q, 0, 0,
                                      ONE_Q, Q16_MAX, Q16_MAX));
        // Entry just short of the limit, then exactly on it.
        rays_to_send.push_back(ray_of(-ONE_Q / 4, HALF_Q, HALF_Q, ONE_Q, 0, 0,
                                      ONE_Q, Q16_MAX, Q16_MAX));
        rays_to_send.push_back(ray_of(-HALF_Q, HALF_Q, HALF_Q, ONE_Q, 0, 0,
                                      ONE_Q, Q16_MAX, Q16_MAX));
        // Origin inside the box.
        rays_to_send.push_back(ray_of(HALF_Q, HALF_Q, HALF_Q, ONE_Q, 0, 0,
                                      ONE_Q, Q16_MAX, Q16_MAX));
        // Diagonal onto the corner: the three low planes tie, low x face takes priority.
        rays_to_send.push_back(ray_of(-ONE_Q, -ONE_Q, -ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                                      ONE_Q, ONE_Q, ONE_Q));
        // Field extremes and bit patterns.
        rays_to_send.push_back(ray_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        rays_to_send.push_back(ray_of(Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX,
                                      Q16_MAX, Q16_MAX, Q16_MAX, Q16_MAX));
        rays_to_send.push_back(ray_of(Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN,
                                      Q16_MIN, Q16_MIN, Q16_MIN, Q16_MIN));
        rays_to_send.push_back(ray_of(32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                      32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
                                      32'h5555_5555, 32'h5555_5555, 32'h5555_5555));
        rays_to_send.push_back(ray_of(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                      32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                      32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        // Shadow registers start at their reset values.
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = longint'(BOX_MIN_RST);
            box_hi[a] = longint'(BOX_MAX_RST);
        end
        min_dist = longint'(MIN_DIST_RST);
        face_tol = longint'(FACE_TOL_RST);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset box, full rate: directed rays, then random ones.
        queue_directed();
        drain_pipe();
        queue_rays(150);
        drain_pipe();

        // Random box with sender gaps; pause for a full drain mid-phase.
        random_box(1'b0);
        set_traffic(TRAFFIC_SEND_GAPS);
        queue_rays(100);
        drain_pipe();
        queue_rays(100);
        drain_pipe();

        // Receiver stalls, plus one long hold-off while the sender keeps
        // offering, so the pipe fills and backs up into the input.
        random_box(1'b0);
        set_traffic(TRAFFIC_RECV_STALLS);
        queue_rays(180);
        repeat (20) @(posedge i_clk);
        holdoff_start <= 1'b1;
        @(posedge i_clk);
        holdoff_start <= 1'b0;
        drain_pipe();

        // Gaps on both sides.
        random_box(1'b0);
        set_traffic(TRAFFIC_BOTH);
        queue_rays(180);
        drain_pipe();

        // Widest possible box, no entry limit, widest tolerance (top bit masked).
        set_traffic(TRAFFIC_STEADY);
        for (int a = 0; a < 3; a++) begin
            write_reg(MIN_REG[a], 32'h8000_0000);
            write_reg(MAX_REG[a], 32'h7FFF_FFFF);
        end
        write_reg(CFG_MIN_DIST, 32'h0000_0000);
        write_reg(CFG_FACE_TOL, 32'hFFFF_FFFF);
        queue_rays(130);
        drain_pipe();

        // Swapped corners, no entry limit, zero tolerance: hits carry no face.
        random_box(1'b1);
        write_reg(CFG_MIN_DIST, 32'h8000_0000);
        write_reg(CFG_FACE_TOL, 32'h0000_0000);
        set_traffic(TRAFFIC_BOTH);
        queue_rays(150);
        drain_pipe();

        // Inverted extreme box with the largest entry limit.
        for (int a = 0; a < 3; a++) begin
            write_reg(MIN_REG[a], 32'h7FFF_FFFF);
            write_reg(MAX_REG[a], 32'h8000_0000);
        end
        write_reg(CFG_MIN_DIST, 32'h7FFF_FFFF);
        write_reg(CFG_FACE_TOL, 32'h7FFF_FFFF);
        set_traffic(TRAFFIC_SEND_GAPS);
        queue_rays(100);
        drain_pipe();

        if (mismatch_count == 0 && predicted_hits.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== ray_box_slab_intersect_top.f =====
+incdir+design
design/rbs_pkg.sv
design/rbs_slab.sv
design/rbs_hitpt.sv
design/ray_box_slab_intersect_top.sv
design/rbs_checker.sv
test/ray_box_slab_intersect_top_tb.sv
